@@ src/aqi_pli_pkg.sv @@
// types, breakpoint table and constants for the air quality index block
package aqi_pli_pkg;

  localparam int unsigned ROW_COUNT = 18;
  localparam int unsigned ROW_W = $clog2(ROW_COUNT);
  localparam int unsigned CONC_W = 16;
  localparam int unsigned DIFF_W = 10;
  localparam int unsigned PRODUCT_BITS = 17;
  localparam int unsigned PROD_SHIFT = PRODUCT_BITS + DIFF_W;
  localparam int unsigned SLOPE_W = 7;
  localparam int unsigned ILO_W = 9;
  localparam int unsigned INDEX_W = 13;
  localparam int unsigned CAT_W = 3;

  localparam logic [1:0] POL_CO = 2'd0;
  localparam logic [1:0] POL_PM25 = 2'd1;
  localparam logic [1:0] POL_PM10 = 2'd2;

  localparam logic [CAT_W-1:0] CAT_GOOD = 3'd0;
  localparam logic [CAT_W-1:0] CAT_MODERATE = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SENSITIVE = 3'd2;
  localparam logic [CAT_W-1:0] CAT_UNHEALTHY = 3'd3;
  localparam logic [CAT_W-1:0] CAT_VERY_UNHEALTHY = 3'd4;
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS = 3'd5;

  localparam logic [1:0] ROW_POL [ROW_COUNT] = '{
    POL_CO, POL_CO, POL_CO, POL_CO, POL_CO, POL_CO,
    POL_PM25, POL_PM25, POL_PM25, POL_PM25, POL_PM25, POL_PM25,
    POL_PM10, POL_PM10, POL_PM10, POL_PM10, POL_PM10, POL_PM10
  };

  localparam logic [CONC_W-1:0] ROW_CLO [ROW_COUNT] = '{
    16'd0, 16'd45, 16'd95, 16'd125, 16'd155, 16'd305,
    16'd0, 16'd121, 16'd355, 16'd555, 16'd1505, 16'd2505,
    16'd0, 16'd550, 16'd1550, 16'd2550, 16'd3550, 16'd4250
  };

  localparam logic [CONC_W-1:0] ROW_CHI [ROW_COUNT] = '{
    16'd44, 16'd94, 16'd124, 16'd154, 16'd304, 16'd404,
    16'd120, 16'd354, 16'd554, 16'd1504, 16'd2504, 16'd3504,
    16'd540, 16'd1540, 16'd2540, 16'd3540, 16'd4240, 16'd5040
  };

  localparam logic [ILO_W-1:0] ROW_ILO [ROW_COUNT] = '{
    9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301,
    9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301,
    9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301
  };

  localparam logic [ILO_W-1:0] ROW_IHI [ROW_COUNT] = '{
    9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400,
    9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400,
    9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400
  };

  localparam logic [CAT_W-1:0] ROW_CAT [ROW_COUNT] = '{
    CAT_GOOD, CAT_MODERATE, CAT_SENSITIVE, CAT_UNHEALTHY, CAT_VERY_UNHEALTHY, CAT_HAZARDOUS,
    CAT_GOOD, CAT_MODERATE, CAT_SENSITIVE, CAT_UNHEALTHY, CAT_VERY_UNHEALTHY, CAT_HAZARDOUS,
    CAT_GOOD, CAT_MODERATE, CAT_SENSITIVE, CAT_UNHEALTHY, CAT_VERY_UNHEALTHY, CAT_HAZARDOUS
  };

  typedef struct packed {
    logic [1:0]        pollutant;
    logic [CONC_W-1:0] concentration_tenths;
  } sample_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index_sixteenths;
    logic [CAT_W-1:0]   category;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [ROW_W-1:0]  row;
    logic [DIFF_W-1:0] diff;
  } match_t;

endpackage

@@ src/aqi_pli_lookup.sv @@
// breakpoint row match and offset into the matched row
module aqi_pli_lookup
  import aqi_pli_pkg::*;
(
  input  sample_t sample,
  output match_t  match
);

  logic [ROW_COUNT-1:0] hit;
  logic [ROW_W-1:0]     row_or;
  logic [DIFF_W-1:0]    diff_or;
  logic [CONC_W-1:0]    offset;

  always_comb begin
    row_or = '0;
    diff_or = '0;
    offset = '0;
    for (int unsigned g = 0; g < ROW_COUNT; g++) begin
      hit[g] = (sample.pollutant == ROW_POL[g]) &&
               (sample.concentration_tenths >= ROW_CLO[g]) &&
               (sample.concentration_tenths <= ROW_CHI[g]);
      offset = sample.concentration_tenths - ROW_CLO[g];
      if (hit[g]) begin
        row_or = row_or | ROW_W'(g);
        diff_or = diff_or | offset[DIFF_W-1:0];
      end
    end
  end

  // rows of one pollutant never overlap, so at most one hit
  assign match.found = |hit;
  assign match.row = row_or;
  assign match.diff = diff_or;

endmodule

@@ src/aqi_piecewise_linear_index_top.sv @@
// air quality index by breakpoint interpolation, four register stages
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+------------------------
//   sample   | sample_valid  | sample_stall  | sample (sample_t)
//   result   | result_valid  | result_stall  | result (result_t)
//
// one item per cycle while result_stall does not hold the result
// stages: input register, row match, slope multiply, index sum
// rst clears the stage valid bits only
// a stall holds the result; earlier stages keep filling while they have room
module aqi_piecewise_linear_index_top
  import aqi_pli_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int unsigned KM_W = PROD_SHIFT + FRAC_BITS + 4;
  localparam int unsigned P_W = DIFF_W + KM_W;
  localparam int unsigned Q_W = SLOPE_W + FRAC_BITS;
  localparam int unsigned SUM_W = (ILO_W + 1 + FRAC_BITS > INDEX_W) ?
                                  ILO_W + 1 + FRAC_BITS : INDEX_W;

  logic [KM_W-1:0] km_table [ROW_COUNT];

  for (genvar g = 0; g < ROW_COUNT; g++) begin : g_row
    localparam logic [63:0] SPAN = 64'(ROW_CHI[g]) - 64'(ROW_CLO[g]);
    localparam logic [63:0] RECIP = ((64'd1 << (PROD_SHIFT + FRAC_BITS)) + SPAN - 64'd1) / SPAN;
    localparam logic [63:0] KM = RECIP * (64'(ROW_IHI[g]) - 64'(ROW_ILO[g]));
    assign km_table[g] = KM[KM_W-1:0];
  end

  logic ready1, ready2, ready3, ready4;
  logic v1, v2, v3;

  sample_t            s1;
  match_t             m2;
  match_t             m2_next;
  logic               found3;
  logic [ILO_W-1:0]   ilo3;
  logic [CAT_W-1:0]   cat3;
  logic [Q_W-1:0]     q3;
  logic [P_W-1:0]     prod;
  logic [SUM_W-1:0]   sum;

  assign ready4 = !result_valid || !result_stall;
  assign ready3 = !v3 || ready4;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign sample_stall = !ready1;

  aqi_pli_lookup u_lookup (
    .sample (s1),
    .match  (m2_next)
  );

  assign prod = {{KM_W{1'b0}}, m2.diff} * {{DIFF_W{1'b0}}, km_table[m2.row]};
  assign sum = (SUM_W'(ilo3) << FRAC_BITS) + SUM_W'(q3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= sample_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) s1 <= sample;
    if (ready2) m2 <= m2_next;
    if (ready3) begin
      found3 <= m2.found;
      ilo3 <= ROW_ILO[m2.row];
      cat3 <= ROW_CAT[m2.row];
      q3 <= prod[PROD_SHIFT +: Q_W];
    end
    if (ready4) begin
      result.found <= found3;
      result.index_sixteenths <= found3 ? sum[INDEX_W-1:0] : '0;
      result.category <= found3 ? cat3 : CAT_GOOD;
    end
  end

endmodule

@@ src/aqi_pli_checker.sv @@
// port checks for the air quality index block, bound to the top level
module aqi_pli_checker
  import aqi_pli_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // a free output never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !sample_stall)
    else $error("input stalled with output free");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.index_sixteenths == '0 && result.category == CAT_GOOD)
    else $error("miss with nonzero index or category");

  a_cat_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.category <= CAT_HAZARDOUS)
    else $error("category out of range");

endmodule

bind aqi_piecewise_linear_index_top aqi_pli_checker u_checker (.*);
